@@ design/f2h_pkg.sv @@
// ----------------------------------------------------------------------------
// f2h_pkg: shared types and constants for the binary32 to binary16 converter
// ----------------------------------------------------------------------------
package f2h_pkg;

   localparam int unsigned SingleWidth = 32;
   localparam int unsigned HalfWidth   = 16;

   localparam logic [7:0]  ExpMax       = 8'd255;
   localparam logic [7:0]  ExpOvfLimit  = 8'd142;
   localparam logic [7:0]  ExpNormMin   = 8'd113;
   localparam logic [7:0]  ExpSubMin    = 8'd102;
   localparam logic [7:0]  RelBias      = 8'd112;
   localparam logic [7:0]  SubShiftBase = 8'd126;

   localparam logic [14:0] HalfInfBits  = 15'h7C00;
   localparam logic [14:0] HalfQnanMant = 15'h0200;

   typedef logic [SingleWidth-1:0] single_type;
   typedef logic [HalfWidth-1:0]   half_type;

endpackage

@@ design/f2h_req_if.sv @@
// ----------------------------------------------------------------------------
// f2h_req_if: request channel carrying one binary32 pattern
// ----------------------------------------------------------------------------
interface f2h_req_if;
   logic                valid;
   logic                ready;
   f2h_pkg::single_type single_bits;

   modport source (output valid, output single_bits, input ready);
   modport sink   (input valid, input single_bits, output ready);
endinterface

@@ design/f2h_rsp_if.sv @@
// ----------------------------------------------------------------------------
// f2h_rsp_if: response channel carrying one binary16 pattern
// ----------------------------------------------------------------------------
interface f2h_rsp_if;
   logic              valid;
   logic              ready;
   f2h_pkg::half_type half_bits;

   modport source (output valid, output half_bits, input ready);
   modport sink   (input valid, input half_bits, output ready);
endinterface

@@ design/f2h_core.sv @@
// ----------------------------------------------------------------------------
// f2h_core: combinational binary32 to binary16 conversion
// ----------------------------------------------------------------------------
module f2h_core (
   input  f2h_pkg::single_type single_bits,
   output f2h_pkg::half_type   half_bits
);
   logic [7:0]  e;
   logic [22:0] m;
   logic [23:0] p;
   logic [4:0]  s;
   logic [7:0]  s_full;
   logic [23:0] p_shift;
   logic [23:0] p_rnd;
   logic [14:0] mag;

   assign e       = single_bits[30:23];
   assign m       = single_bits[22:0];
   assign p       = {1'b1, m};
   assign s_full  = f2h_pkg::SubShiftBase - e;
   assign s       = s_full[4:0];
   assign p_shift = p >> s;
   assign p_rnd   = p >> (s - 5'd1);

   always_comb begin
      if (e == 8'd0) begin
         mag = '0;
      end else if (e == f2h_pkg::ExpMax) begin
         mag = (m != '0) ? (f2h_pkg::HalfInfBits | f2h_pkg::HalfQnanMant)
                         : f2h_pkg::HalfInfBits;
      end else if (e > f2h_pkg::ExpOvfLimit) begin
         mag = f2h_pkg::HalfInfBits;
      end else if (e >= f2h_pkg::ExpNormMin) begin
         // rounding carry may ripple into the exponent
         mag = {5'(e - f2h_pkg::RelBias), m[22:13]} + {14'd0, m[12]};
      end else if (e >= f2h_pkg::ExpSubMin) begin
         mag = {5'd0, p_shift[9:0]} + {14'd0, p_rnd[0]};
      end else begin
         mag = '0;
      end
   end

   assign half_bits = {single_bits[31], mag};
endmodule

@@ design/fp32_to_fp16_convert.sv @@
// ----------------------------------------------------------------------------
// fp32_to_fp16_convert: binary32 to binary16 converter
//
// A request carries one binary32 pattern on req; one binary16 response with
// the same sign comes out on rsp for every request, in order. Rounding is
// half-up on the magnitude; NaNs become quiet NaN, tiny values flush to zero.
// The request is first captured in an input register, and is then
// converted by one pass of combinational logic into the result register.
// Throughput is one request per cycle while rsp_ready is high, set by the two-stage register pipe.
// Each stage holds when the stage after it is full and not drained, so a
// stalled rsp_ready backs up into req_ready without losing or repeating data.
// Synchronous reset empties both stages; payload registers are not cleared.
// ----------------------------------------------------------------------------
module fp32_to_fp16_convert (
   input logic      clock,
   input logic      reset,
   f2h_req_if.sink  req,
   f2h_rsp_if.source rsp
);
   logic                in_vld_ff, in_vld_in;
   f2h_pkg::single_type in_data_ff, in_data_in;
   logic                out_vld_ff, out_vld_in;
   f2h_pkg::half_type   out_data_ff, out_data_in;
   f2h_pkg::half_type   conv;
   logic                out_load;
   logic                in_load;

   f2h_core u_core (.single_bits(in_data_ff), .half_bits(conv));

   assign out_load  = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign in_load   = !in_vld_ff || out_load;
   assign req.ready = in_load;

   always_comb begin
      in_vld_in   = in_load ? req.valid : in_vld_ff;
      in_data_in  = (in_load && req.valid) ? req.single_bits : in_data_ff;
      out_vld_in  = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_ff);
      out_data_in = out_load ? conv : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp.valid     = out_vld_ff;
   assign rsp.half_bits = out_data_ff;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp.ready |=> out_vld_ff && $stable(out_data_ff))
      else $error("response lost or changed under stall");
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !out_load |=> in_vld_ff && $stable(in_data_ff))
      else $error("input stage lost a request");
   a_conv: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_data_ff == $past(conv))
      else $error("result register not loaded with conversion");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req.ready)
      else $error("empty input stage refused a request");
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the binary32 to binary16 converter
//
// A table of directed requests (zeros, infinities, NaNs, range edges,
// rounding carries) is sent first, then random requests biased toward the
// interesting exponent ranges. Each response is checked against an in-order
// queue of expected half patterns built by a local conversion function.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NumRandom = 630;
   localparam int StallLimit = 2000;
   localparam int LongHold = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   f2h_req_if req ();
   f2h_rsp_if rsp ();

   fp32_to_fp16_convert u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   typedef struct {
      f2h_pkg::single_type single_bits;
      bit                  has_half;
      f2h_pkg::half_type   half_bits;
   } vector_type;

   f2h_pkg::half_type half_queue[$];
   int       errors = 0;
   int       idle_cycles = 0;
   bit       quiet_phase = 1'b0;
   bit       hold_rsp = 1'b0;
   bit       sent_all = 1'b0;

   function automatic f2h_pkg::half_type to_half(f2h_pkg::single_type x);
      logic [7:0]  e;
      logic [22:0] m;
      logic [23:0] p;
      logic [14:0] mag;
      int          s;
      e = x[30:23];
      m = x[22:0];
      if (e == 8'd0) mag = '0;
      else if (e == f2h_pkg::ExpMax)
         mag = (m != 0) ? (f2h_pkg::HalfInfBits | f2h_pkg::HalfQnanMant)
                        : f2h_pkg::HalfInfBits;
      else if (e > f2h_pkg::ExpOvfLimit) mag = f2h_pkg::HalfInfBits;
      else if (e >= f2h_pkg::ExpNormMin) begin
         mag = {5'(e - f2h_pkg::RelBias), m[22:13]};
         mag = mag + 15'(m[12]);
      end else if (e >= f2h_pkg::ExpSubMin) begin
         p = {1'b1, m};
         s = int'(f2h_pkg::SubShiftBase) - int'(e);
         mag = 15'((p >> s) & 24'h3FF);
         mag = mag + 15'((p >> (s - 1)) & 24'h1);
      end else mag = '0;
      return {x[31], mag};
   endfunction

   // directed requests; expected value typed in where obvious
   vector_type directed[] = '{
      '{32'h0000_0000, 1, 16'h0000}, '{32'h8000_0000, 1, 16'h8000},
      '{32'h007F_FFFF, 1, 16'h0000}, '{32'h807F_FFFF, 1, 16'h8000},
      '{32'h7F80_0000, 1, 16'h7C00}, '{32'hFF80_0000, 1, 16'hFC00},
      '{32'h7FFF_FFFF, 1, 16'h7E00}, '{32'hFF80_0001, 1, 16'hFE00},
      '{32'h4780_0000, 1, 16'h7C00}, '{32'h7F7F_FFFF, 1, 16'h7C00},
      '{32'h3F80_0000, 1, 16'h3C00}, '{32'h477F_E000, 1, 16'h7BFF},
      '{32'h477F_F000, 1, 16'h7C00}, '{32'h3880_0000, 1, 16'h0400},
      '{32'h3800_0000, 1, 16'h0200}, '{32'h3300_0000, 1, 16'h0001},
      '{32'h3300_0001, 1, 16'h0001}, '{32'h33FF_FFFF, 1, 16'h0002},
      '{32'h387F_FFFF, 0, 16'h0000}, '{32'hB87F_F000, 0, 16'h0000},
      '{32'h3280_0000, 1, 16'h0000}, '{32'h0080_0000, 1, 16'h0000},
      '{32'hBF80_1000, 0, 16'h0000}, '{32'h4000_0FFF, 0, 16'h0000},
      '{32'hFFFF_FFFF, 1, 16'hFE00}
   };

   function automatic f2h_pkg::single_type random_single();
      logic [7:0] e;
      case ($urandom_range(0, 5))
         0: e = 8'($urandom_range(113, 142));
         1: e = 8'($urandom_range(102, 112));
         2: e = 8'($urandom_range(141, 144));
         3: e = ($urandom_range(0, 1) != 0) ? 8'd0 : f2h_pkg::ExpMax;
         4: e = 8'($urandom_range(99, 114));
         default: e = 8'($urandom);
      endcase
      return {1'($urandom), e, 23'($urandom)};
   endfunction

   task automatic send_request(f2h_pkg::single_type x);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.single_bits <= x;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      half_queue.push_back(to_half(x));
   endtask

   // stimulus
   initial begin
      req.valid = 1'b0;
      req.single_bits = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_request(directed[i].single_bits);
         if (directed[i].has_half &&
             to_half(directed[i].single_bits) != directed[i].half_bits) begin
            $error("half_bits table: expected %h actual %h", directed[i].half_bits,
                   to_half(directed[i].single_bits));
            errors++;
         end
      end
      // long receiver hold while requests keep coming
      hold_rsp <= 1'b1;
      for (int i = 0; i < 60; i++) begin
         if (i == 20) hold_rsp <= 1'b0;
         send_request(random_single());
      end
      req.valid <= 1'b0;
      // pause until drained
      while (half_queue.size() != 0) @(posedge clock);
      for (int i = 0; i < NumRandom - 60; i++) begin
         if (i == NumRandom - 160) quiet_phase <= 1'b1;
         send_request(random_single());
      end
      req.valid <= 1'b0;
      sent_all <= 1'b1;
   end

   // receiver: random stall bursts, plus the long hold
   int hold_count = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_count <= 0;
      end else if (hold_rsp && hold_count < LongHold) begin
         hold_count <= hold_count + 1;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // response check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (half_queue.size() == 0) begin
               $error("half_bits: unexpected response %h", rsp.half_bits);
               errors++;
            end else begin
               if (rsp.half_bits !== half_queue[0]) begin
                  $error("half_bits: expected %h actual %h", half_queue[0], rsp.half_bits);
                  errors++;
               end
               void'(half_queue.pop_front());
            end
         end
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= StallLimit) begin
            $display("tb_top: errors");
            $finish;
         end
         if (sent_all && half_queue.size() == 0) begin
            repeat (10) @(posedge clock);
            if (errors == 0 && half_queue.size() == 0) $display("tb_top: clean");
            else $display("tb_top: errors");
            $finish;
         end
      end
   end

endmodule
